// ----- hdl/oets_pkg.sv -----
// Shared constants and types for the odd-even transposition sorter.
package oets_pkg;

	localparam int DEPTH  = 64;
	localparam int WORD_W = 32;
	localparam int CNT_W  = $clog2(DEPTH + 1);

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic [CNT_W-1:0]         count_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_SORT,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_UNLOAD,
		CELL_EXCH
	} cell_op_t;

	typedef enum logic [1:0] {
		ROLE_NONE,
		ROLE_LO,
		ROLE_HI
	} cell_role_t;

	typedef struct packed {
		cell_op_t   op;
		cell_role_t role;
	} cell_ctrl_t;

endpackage

// ----- hdl/oets_cell.sv -----
// One storage cell of the sorting chain with its compare-exchange logic.
module oets_cell (
	input  logic                clk,
	input  oets_pkg::cell_ctrl_t ctrl,
	input  oets_pkg::word_t     left_val,
	input  oets_pkg::word_t     right_val,
	input  logic                left_gt,
	output logic                gt_right,
	output oets_pkg::word_t     val
);

	oets_pkg::word_t val_q;
	oets_pkg::word_t val_d;

	assign gt_right = val_q > right_val;
	assign val      = val_q;

	always_comb begin
		val_d = val_q;
		case (ctrl.op)
			oets_pkg::CELL_LOAD: begin
				val_d = left_val;
			end
			oets_pkg::CELL_UNLOAD: begin
				val_d = right_val;
			end
			oets_pkg::CELL_EXCH: begin
				// Lower member keeps the minimum, upper member the maximum.
				if (ctrl.role == oets_pkg::ROLE_LO && gt_right) begin
					val_d = right_val;
				end else if (ctrl.role == oets_pkg::ROLE_HI && left_gt) begin
					val_d = left_val;
				end
			end
			default: begin
				val_d = val_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		val_q <= val_d;
	end

endmodule

// ----- hdl/odd_even_transposition_sorter.sv -----
// Top level of the odd-even transposition sorter: control and the row of cells.
//
// Usage: values enter on the input channel (value, final_item), one per beat.
// A beat with final_item set closes the set and starts the sort. Only the first
// DEPTH values of a set are kept; later ones are dropped, but a final_item mark
// still starts the sort. The input channel stalls from the final beat until
// the last sorted value has been moved into the output register.
//
// Loading: each value enters cell 0 and the row shifts up by one. Sorting runs
// one compare-exchange pass per cycle, odd pairs and even pairs in turn, and
// stops after the first odd/even pair of passes without a swap. Results then
// leave from cell 0, smallest first, one per cycle while out_stall allows, as
// the row shifts down, with last_result set on the final one.
//
// The output register decouples the receiver: while a held beat is stalled by
// out_stall, it stays unchanged and the row simply waits. Reset clears the
// control state (empty set, loading, no output beat); the cell contents are
// not reset, since only cells written in the current set are ever read.
module odd_even_transposition_sorter (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic signed [31:0]     value,
	input  logic                   final_item,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic signed [31:0]     sorted_value,
	output logic                   last_result
);

	oets_pkg::state_t state_q;
	oets_pkg::state_t state_d;
	oets_pkg::count_t count_q;
	oets_pkg::count_t count_d;
	logic             phase_q;     // 0: odd pass, 1: even pass
	logic             phase_d;
	logic             swap_q;      // a swap happened in the current pass pair
	logic             swap_d;
	logic             out_valid_q;
	oets_pkg::word_t  sorted_value_q;
	logic             last_result_q;

	logic             in_beat;
	logic             emit_go;
	logic             swap_now;
	oets_pkg::cell_op_t op;

	oets_pkg::cell_ctrl_t ctrl   [oets_pkg::DEPTH];
	oets_pkg::word_t      cell_v [oets_pkg::DEPTH];
	logic [oets_pkg::DEPTH-1:0] gt;
	logic [oets_pkg::DEPTH-1:0] lo_swap;

	assign in_stall     = (state_q != oets_pkg::ST_LOAD);
	assign in_beat      = in_valid && !in_stall;
	assign emit_go      = (state_q == oets_pkg::ST_EMIT) && (count_q != '0)
	                      && (!out_valid_q || !out_stall);
	assign swap_now     = |lo_swap;
	assign out_valid    = out_valid_q;
	assign sorted_value = sorted_value_q;
	assign last_result  = last_result_q;

	// Row of cells. A value shifts up on load and down on unload; during the
	// sort each active pair of neighbors does one compare-exchange per cycle.
	for (genvar i = 0; i < oets_pkg::DEPTH; i++) begin : g_cell
		localparam logic LO_ODD = (i % 2) == 1;
		logic lo_act;
		logic hi_act;

		// Cell i is the lower member of pair (i, i+1) when its parity fits
		// the pass and both cells hold loaded values.
		assign lo_act = (i + 1 < oets_pkg::DEPTH)
		                && ((LO_ODD && !phase_q) || (!LO_ODD && phase_q))
		                && (count_q > oets_pkg::count_t'(i + 1));
		if (i == 0) begin : g_first
			assign hi_act = 1'b0;
		end else begin : g_rest
			assign hi_act = g_cell[i-1].lo_act;
		end

		assign lo_swap[i] = lo_act && gt[i] && (state_q == oets_pkg::ST_SORT);
		assign ctrl[i].op   = op;
		assign ctrl[i].role = lo_act ? oets_pkg::ROLE_LO :
		                      hi_act ? oets_pkg::ROLE_HI : oets_pkg::ROLE_NONE;

		oets_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl[i]),
			.left_val  ((i == 0) ? value : cell_v[(i == 0) ? 0 : i - 1]),
			.right_val ((i == oets_pkg::DEPTH - 1) ? cell_v[i] :
			            cell_v[(i == oets_pkg::DEPTH - 1) ? i : i + 1]),
			.left_gt   ((i == 0) ? 1'b0 : gt[(i == 0) ? 0 : i - 1]),
			.gt_right  (gt[i]),
			.val       (cell_v[i])
		);
	end

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		phase_d = phase_q;
		swap_d  = swap_q;
		op      = oets_pkg::CELL_HOLD;
		case (state_q)
			oets_pkg::ST_LOAD: begin
				if (in_beat) begin
					// Values past the store depth are dropped.
					if (count_q != oets_pkg::count_t'(oets_pkg::DEPTH)) begin
						op      = oets_pkg::CELL_LOAD;
						count_d = count_q + 1'b1;
					end
					if (final_item) begin
						state_d = oets_pkg::ST_SORT;
						phase_d = 1'b0;
						swap_d  = 1'b0;
					end
				end
			end
			oets_pkg::ST_SORT: begin
				op      = oets_pkg::CELL_EXCH;
				phase_d = !phase_q;
				if (phase_q) begin
					// End of a pass pair: finished when neither pass swapped.
					swap_d = 1'b0;
					if (!swap_q && !swap_now) begin
						state_d = oets_pkg::ST_EMIT;
					end
				end else begin
					swap_d = swap_now;
				end
			end
			oets_pkg::ST_EMIT: begin
				if (emit_go) begin
					op      = oets_pkg::CELL_UNLOAD;
					count_d = count_q - 1'b1;
					if (count_q == oets_pkg::count_t'(1)) begin
						state_d = oets_pkg::ST_LOAD;
					end
				end
			end
			default: begin
				state_d = oets_pkg::ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= oets_pkg::ST_LOAD;
			count_q     <= '0;
			phase_q     <= 1'b0;
			swap_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			phase_q <= phase_d;
			swap_q  <= swap_d;
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output payload, taken from the bottom cell as the row shifts down.
	always_ff @(posedge clk) begin
		if (emit_go) begin
			sorted_value_q <= cell_v[0];
			last_result_q  <= (count_q == oets_pkg::count_t'(1));
		end
	end

endmodule

// ----- hdl/oets_checker.sv -----
// Port-level checker for the odd-even transposition sorter, with its bind.
module oets_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic signed [31:0] value,
	input logic              final_item,
	input logic              out_valid,
	input logic              out_stall,
	input logic signed [31:0] sorted_value,
	input logic              last_result
);

	// A stalled output beat holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sorted_value)
		&& $stable(last_result))
		else $error("stalled output beat changed");

	// The final input beat closes the set, so the input must stall next.
	a_final_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && final_item |=> in_stall)
		else $error("input not stalled after final beat");

	// While a run is still being emitted no new values are taken.
	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_result |-> in_stall)
		else $error("input open during an unfinished run");

	// A non-final output beat that is taken is followed by another beat.
	a_run_cont: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_result |=> out_valid)
		else $error("run ended without last_result");

endmodule

bind odd_even_transposition_sorter oets_checker u_oets_checker (.*);
